@@ rtl/core/dcf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCF77 decoder package
// Shared widths, bit positions, register indexes, payload structs and the
// BCD conversion used by the DCF77 pulse time decoder.
// ----------------------------------------------------------------------------
package dcf_pkg;

  // Timestamp and frame geometry.
  localparam int unsigned TsW    = 32;
  localparam int unsigned FrameW = 60;
  localparam int unsigned PosW   = 6;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Register widths.
  localparam int unsigned SplitW   = 10;
  localparam int unsigned SyncGapW = 12;
  localparam int unsigned GlitchW  = 10;

  // Time field widths.
  localparam int unsigned MinW   = 7;
  localparam int unsigned HourW  = 6;
  localparam int unsigned DayW   = 6;
  localparam int unsigned MonW   = 5;
  localparam int unsigned YearW  = 8;

  // Reset values of the configuration registers.
  localparam logic [SplitW-1:0]   SplitRst   = SplitW'(140);
  localparam logic [SyncGapW-1:0] SyncGapRst = SyncGapW'(1200);
  localparam logic [GlitchW-1:0]  GlitchRst  = GlitchW'(300);
  localparam logic [TsW-1:0]      TimeoutRst = TsW'(120 * 1000);

  // Bit positions inside the minute frame.
  localparam logic [PosW-1:0] PosMinStart  = PosW'(21);
  localparam logic [PosW-1:0] PosMinPar    = PosW'(28);
  localparam logic [PosW-1:0] PosHourStart = PosW'(29);
  localparam logic [PosW-1:0] PosHourPar   = PosW'(35);
  localparam logic [PosW-1:0] PosDateStart = PosW'(36);
  localparam logic [PosW-1:0] PosDatePar   = PosW'(58);
  localparam logic [PosW-1:0] PosLast      = PosW'(59);

  // Low bit of each BCD field.
  localparam int unsigned MinLo  = 21;
  localparam int unsigned HourLo = 29;
  localparam int unsigned DayLo  = 36;
  localparam int unsigned MonLo  = 45;
  localparam int unsigned YearLo = 50;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgInvert  = 3'd0,
    CfgSplit   = 3'd1,
    CfgSyncGap = 3'd2,
    CfgGlitch  = 3'd3,
    CfgTimeout = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                invert_signal;
    logic [SplitW-1:0]   split_ms;
    logic [SyncGapW-1:0] sync_gap_ms;
    logic [GlitchW-1:0]  glitch_ms;
    logic [TsW-1:0]      sync_timeout_ms;
  } dcf_cfg_t;

  typedef struct packed {
    logic           raw_level;
    logic [TsW-1:0] now_ms;
  } dcf_item_t;

  typedef struct packed {
    logic [MinW-1:0]  minute_out;
    logic [HourW-1:0] hour_out;
    logic [DayW-1:0]  day_out;
    logic [MonW-1:0]  month_out;
    logic [YearW-1:0] year_out;
    logic             synced_flag;
    logic             frame_accepted;
    logic             bit_taken;
    logic             bit_value;
  } dcf_res_t;

  // BCD to binary without range check: v - 6 * (v >> 4), wrapping.
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    logic [7:0] hi;
    hi = {4'b0000, v[7:4]};
    return v - ((hi << 2) + (hi << 1));
  endfunction

endpackage

@@ rtl/core/dcf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCF77 sample channel
// Valid/ready channel that carries one receiver sample with its timestamp.
// ----------------------------------------------------------------------------
interface dcf_in_if
  import dcf_pkg::*;
;
  logic           valid;
  logic           ready;
  logic           raw_level;
  logic [TsW-1:0] now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

@@ rtl/core/dcf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCF77 result channel
// Valid/ready channel that carries the decoded time and event flags.
// ----------------------------------------------------------------------------
interface dcf_out_if
  import dcf_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [MinW-1:0]  minute_out;
  logic [HourW-1:0] hour_out;
  logic [DayW-1:0]  day_out;
  logic [MonW-1:0]  month_out;
  logic [YearW-1:0] year_out;
  logic             synced_flag;
  logic             frame_accepted;
  logic             bit_taken;
  logic             bit_value;

  modport source (
    output valid, output minute_out, output hour_out, output day_out,
    output month_out, output year_out, output synced_flag,
    output frame_accepted, output bit_taken, output bit_value, input ready
  );
  modport sink (
    input valid, input minute_out, input hour_out, input day_out,
    input month_out, input year_out, input synced_flag,
    input frame_accepted, input bit_taken, input bit_value, output ready
  );
endinterface

@@ rtl/core/dcf77_pulse_time_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCF77 pulse time decoder
// Decodes DCF77 receiver samples into minute, hour and date with sync status.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one receiver sample (raw_level, now_ms) per transfer. Every
//   sample produces exactly one result transfer on out_o, in order.
//   The configuration port writes one register per cycle with cfg_we_i high;
//   write it only while no sample is in flight.
// Flow and throughput:
//   A sample enters an input register at its transfer, is decoded once the
//   result register is free and lands in the result register, which offers
//   its result on out_o. One sample per cycle is sustained while out_o
//   takes every result: the decode step is one pass of logic between the
//   input and result registers, frame state updated in the same cycle.
// Stall:
//   When out_o is not taken, the result register holds and the input
//   register keeps its sample; in_i.ready drops only when both are full.
// Reset:
//   rst_ni clears the frame state, the decoded time and both stage valids,
//   and loads the default thresholds. Decoding starts at the next cycle.
// ----------------------------------------------------------------------------
module dcf77_pulse_time_decoder
  import dcf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  dcf_in_if.sink              in_i,
  dcf_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  dcf_cfg_t  cfg;
  dcf_item_t item_q;
  dcf_res_t  res;
  logic      item_valid_q, item_valid_d;
  logic      out_free;
  logic      fire;
  logic      in_xfer;

  dcf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register: advances into the decoder when the result slot is free.
  assign fire       = item_valid_q && out_free;
  assign in_i.ready = !item_valid_q || fire;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_xfer) begin
      item_valid_d = 1'b1;
    end else if (fire) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.raw_level <= in_i.raw_level;
      item_q.now_ms    <= in_i.now_ms;
    end
  end

  dcf_decode_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (res)
  );

  dcf_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

@@ rtl/core/dcf_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCF77 configuration registers
// Write-only register bank: inversion, pulse split, gap, glitch, timeout.
// ----------------------------------------------------------------------------
module dcf_cfg_regs
  import dcf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output dcf_cfg_t            cfg_o
);

  dcf_cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes write nothing.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgInvert:  cfg_d.invert_signal   = cfg_wdata_i[0];
        CfgSplit:   cfg_d.split_ms        = cfg_wdata_i[SplitW-1:0];
        CfgSyncGap: cfg_d.sync_gap_ms     = cfg_wdata_i[SyncGapW-1:0];
        CfgGlitch:  cfg_d.glitch_ms       = cfg_wdata_i[GlitchW-1:0];
        CfgTimeout: cfg_d.sync_timeout_ms = cfg_wdata_i[TsW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert_signal   <= 1'b0;
      cfg_q.split_ms        <= SplitRst;
      cfg_q.sync_gap_ms     <= SyncGapRst;
      cfg_q.glitch_ms       <= GlitchRst;
      cfg_q.sync_timeout_ms <= TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/dcf_decode_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCF77 decode core
// Holds the frame state and turns one registered sample into one result:
// edge detect, gap measurement, bit shift-in, parity check and BCD load.
// ----------------------------------------------------------------------------
module dcf_decode_core
  import dcf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dcf_cfg_t  cfg_i,
  input  logic      fire_i,
  input  dcf_item_t item_i,
  output dcf_res_t  res_o
);

  logic              last_level_q, last_level_d;
  logic [TsW-1:0]    last_rise_q, last_rise_d;
  logic [PosW-1:0]   bit_pos_q, bit_pos_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic              run_par_q, run_par_d;
  logic [2:0]        saved_par_q, saved_par_d;
  logic [MinW-1:0]   minute_q, minute_d;
  logic [HourW-1:0]  hour_q, hour_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [MonW-1:0]   month_q, month_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [TsW-1:0]    last_frame_q, last_frame_d;

  logic           level;
  logic           changed;
  logic [TsW-1:0] gap;
  logic [TsW-1:0] age;
  logic           par_ok;
  logic           close;
  logic           close_ok;
  logic           bv;
  logic           taken;
  logic [7:0]     min_bin, hour_bin, day_bin, mon_bin, year_bin;

  assign level   = item_i.raw_level ^ cfg_i.invert_signal;
  assign changed = fire_i && (level != last_level_q);
  assign gap     = item_i.now_ms - last_rise_q;
  assign par_ok  = (saved_par_q[0] == frame_q[PosMinPar]) &&
                   (saved_par_q[1] == frame_q[PosHourPar]) &&
                   (saved_par_q[2] == frame_q[PosDatePar]);

  // BCD fields of the frame collected so far.
  assign min_bin  = bcd_to_bin({1'b0, frame_q[MinLo +: MinW]});
  assign hour_bin = bcd_to_bin({2'b00, frame_q[HourLo +: HourW]});
  assign day_bin  = bcd_to_bin({2'b00, frame_q[DayLo +: DayW]});
  assign mon_bin  = bcd_to_bin({3'b000, frame_q[MonLo +: MonW]});
  assign year_bin = bcd_to_bin(frame_q[YearLo +: YearW]);

  // Next state for one accepted sample.
  always_comb begin
    last_level_d = last_level_q;
    last_rise_d  = last_rise_q;
    bit_pos_d    = bit_pos_q;
    frame_d      = frame_q;
    run_par_d    = run_par_q;
    saved_par_d  = saved_par_q;
    minute_d     = minute_q;
    hour_d       = hour_q;
    day_d        = day_q;
    month_d      = month_q;
    year_d       = year_q;
    last_frame_d = last_frame_q;
    close        = 1'b0;
    close_ok     = 1'b0;
    bv           = 1'b0;
    taken        = 1'b0;

    if (changed) begin
      last_level_d = level;
      if (level) begin
        // Rising edge: minute mark, glitch or plain second start.
        if (gap > {{(TsW-SyncGapW){1'b0}}, cfg_i.sync_gap_ms}) begin
          close    = 1'b1;
          close_ok = (bit_pos_q == PosLast) && par_ok;
        end else if (gap < {{(TsW-GlitchW){1'b0}}, cfg_i.glitch_ms}) begin
          if (bit_pos_q != '0) begin
            bit_pos_d = bit_pos_q - PosW'(1);
          end
        end
        if (gap > {{(TsW-GlitchW){1'b0}}, cfg_i.glitch_ms}) begin
          last_rise_d = item_i.now_ms;
        end
      end else begin
        // Falling edge: pulse width picks the bit value.
        bv      = (gap >= {{(TsW-SplitW){1'b0}}, cfg_i.split_ms});
        taken   = 1'b1;
        frame_d = frame_q | (FrameW'(bv) << bit_pos_q);
        if (bit_pos_q inside {PosMinStart, PosHourStart, PosDateStart}) begin
          run_par_d = 1'b0;
        end
        if (bit_pos_q == PosMinPar) begin
          saved_par_d[0] = run_par_q;
        end
        if (bit_pos_q == PosHourPar) begin
          saved_par_d[1] = run_par_q;
        end
        if (bit_pos_q == PosDatePar) begin
          saved_par_d[2] = run_par_q;
        end
        if (bv) begin
          run_par_d = run_par_d ^ 1'b1;
        end
        // A sixtieth bit overruns the frame and closes it unaccepted.
        if (bit_pos_q == PosLast) begin
          close = 1'b1;
        end else begin
          bit_pos_d = bit_pos_q + PosW'(1);
        end
      end
    end

    if (close) begin
      bit_pos_d    = '0;
      frame_d      = '0;
      last_frame_d = item_i.now_ms;
    end

    if (close_ok) begin
      minute_d = min_bin[MinW-1:0];
      hour_d   = hour_bin[HourW-1:0];
      day_d    = day_bin[DayW-1:0];
      month_d  = mon_bin[MonW-1:0];
      year_d   = year_bin[YearW-1:0];
    end
  end

  // Result reflects the state after this sample.
  assign age = item_i.now_ms - last_frame_d;

  always_comb begin
    res_o.minute_out     = minute_d;
    res_o.hour_out       = hour_d;
    res_o.day_out        = day_d;
    res_o.month_out      = month_d;
    res_o.year_out       = year_d;
    res_o.synced_flag    = (day_d != '0) && (month_d != '0) &&
                           (age <= cfg_i.sync_timeout_ms);
    res_o.frame_accepted = close_ok;
    res_o.bit_taken      = taken;
    res_o.bit_value      = bv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      last_rise_q  <= '0;
      bit_pos_q    <= '0;
      frame_q      <= '0;
      run_par_q    <= 1'b0;
      saved_par_q  <= '0;
      minute_q     <= '0;
      hour_q       <= '0;
      day_q        <= '0;
      month_q      <= '0;
      year_q       <= '0;
      last_frame_q <= '0;
    end else begin
      last_level_q <= last_level_d;
      last_rise_q  <= last_rise_d;
      bit_pos_q    <= bit_pos_d;
      frame_q      <= frame_d;
      run_par_q    <= run_par_d;
      saved_par_q  <= saved_par_d;
      minute_q     <= minute_d;
      hour_q       <= hour_d;
      day_q        <= day_d;
      month_q      <= month_d;
      year_q       <= year_d;
      last_frame_q <= last_frame_d;
    end
  end

  // The bit position never runs past the last frame bit.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_pos_q <= PosLast)
    else $error("bit position beyond frame end");

  // A frame is accepted only on a rising edge, a bit is taken on a falling edge.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> !(res_o.frame_accepted && res_o.bit_taken))
    else $error("frame accept and bit take in one sample");

  // An accepted frame leaves an empty frame behind.
  a_accept_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.frame_accepted |=> bit_pos_q == '0 && frame_q == '0)
    else $error("frame state not cleared after accept");

  // Without a sample the decode state holds.
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(bit_pos_q) && $stable(last_level_q) && $stable(frame_q))
    else $error("decode state changed without a sample");

endmodule

@@ rtl/core/dcf_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DCF77 result register
// Holds one result for the output channel until the receiver takes it.
// ----------------------------------------------------------------------------
module dcf_out_stage
  import dcf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  dcf_res_t res_i,
  output logic     free_o,
  dcf_out_if.source out_o
);

  logic     valid_q, valid_d;
  dcf_res_t data_q;

  // The register can take a new result when empty or emptied this cycle.
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.minute_out     = data_q.minute_out;
  assign out_o.hour_out       = data_q.hour_out;
  assign out_o.day_out        = data_q.day_out;
  assign out_o.month_out      = data_q.month_out;
  assign out_o.year_out       = data_q.year_out;
  assign out_o.synced_flag    = data_q.synced_flag;
  assign out_o.frame_accepted = data_q.frame_accepted;
  assign out_o.bit_taken      = data_q.bit_taken;
  assign out_o.bit_value      = data_q.bit_value;

endmodule
